// File: design/vvr_pkg.sv
// Package for the view vector rotator: widths, codes, reset values and the
// arctangent table of the CORDIC.
// Depends on nothing; every other file of the block imports it.
package vvr_pkg;

    // Default number of CORDIC micro-rotations
    localparam int CORDIC_STEPS_DEF = 16;

    // Field and datapath widths
    localparam int DATA_W      = 16;  // Q2.14 components and 16 bit registers
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int LANE_CNT    = 4;
    localparam int LANE_IDX_W  = 2;
    localparam int LANE_W      = 36;  // Q2.30 accumulators with growth headroom
    localparam int Z_W         = 17;  // residual angle in Q3.13
    localparam int MUL_W       = 17;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ATAN_IDX_W  = 5;

    // Fixed-point constants
    localparam logic [DATA_W-1:0] GAIN_K    = 16'd39797;  // CORDIC gain in Q0.16
    localparam logic [Z_W-1:0]    ANGLE_MAX = 17'd12868;  // pi/2 in Q3.13

    // Register reset values
    localparam logic [DATA_W-1:0] RST_ROT_SPEED     = 16'd12288;
    localparam logic [DATA_W-1:0] RST_START_DIR_X   = 16'hC000;
    localparam logic [DATA_W-1:0] RST_START_DIR_Y   = 16'd0;
    localparam logic [DATA_W-1:0] RST_START_PLANE_X = 16'd0;
    localparam logic [DATA_W-1:0] RST_START_PLANE_Y = 16'd10813;

    // Opcodes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_LEFT    = 2'd0,
        OP_RIGHT   = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_SPEED     = 3'd0,
        REG_START_DIR_X   = 3'd1,
        REG_START_DIR_Y   = 3'd2,
        REG_START_PLANE_X = 3'd3,
        REG_START_PLANE_Y = 3'd4
    } t_cfg_reg;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ANG,
        S_SCALE,
        S_START,
        S_RUN,
        S_DONE
    } t_state;

    // Control from the sequencer to the CORDIC unit
    typedef struct packed {
        logic                  wr;
        logic [LANE_IDX_W-1:0] lane;
        logic                  start;
    } t_cor_ctl;

    // Status from the CORDIC unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_cor_stat;

    // atan(2^-i) in Q3.13, rounded to nearest; zero beyond the table
    function automatic logic signed [Z_W-1:0] atan_q13(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            5'd0:    a = 17'sd6434;
            5'd1:    a = 17'sd3798;
            5'd2:    a = 17'sd2007;
            5'd3:    a = 17'sd1019;
            5'd4:    a = 17'sd511;
            5'd5:    a = 17'sd256;
            5'd6:    a = 17'sd128;
            5'd7:    a = 17'sd64;
            5'd8:    a = 17'sd32;
            5'd9:    a = 17'sd16;
            5'd10:   a = 17'sd8;
            5'd11:   a = 17'sd4;
            5'd12:   a = 17'sd2;
            5'd13:   a = 17'sd1;
            default: a = 17'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: design/vvr_in_if.sv
// Input channel of the view vector rotator: valid/ready with opcode and
// frame time. Depends on vvr_pkg.
interface vvr_in_if;
    import vvr_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] frame_time;

    modport source (output valid, output opcode, output frame_time, input ready);
    modport sink   (input valid, input opcode, input frame_time, output ready);
endinterface

// File: design/vvr_out_if.sv
// Output channel of the view vector rotator: valid/ready with the four
// updated vector components. Depends on vvr_pkg.
interface vvr_out_if;
    import vvr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] plane_x;
    logic signed [DATA_W-1:0] plane_y;

    modport source (output valid, output dir_x, output dir_y, output plane_x,
                    output plane_y, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input plane_x,
                    input plane_y, output ready);
endinterface

// File: design/vvr_cordic.sv
// Iterative CORDIC unit: one shared micro-rotation step applied to two
// vectors (four lanes) per cycle, then rounding to Q2.14. Depends on vvr_pkg.
module vvr_cordic #(
    parameter int CORDIC_STEPS = vvr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  vvr_pkg::t_cor_ctl                            i_ctl,
    input  logic signed [vvr_pkg::LANE_W-1:0]            i_wr_data,
    input  logic signed [vvr_pkg::Z_W-1:0]               i_z,
    output vvr_pkg::t_cor_stat                           o_stat,
    output logic [vvr_pkg::LANE_CNT-1:0][vvr_pkg::DATA_W-1:0] o_res
);
    import vvr_pkg::*;

    localparam int                STEP_W    = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    logic signed [LANE_W-1:0] r_x [LANE_CNT];
    logic signed [LANE_W-1:0] n_x [LANE_CNT];
    logic signed [LANE_W-1:0] w_sh [LANE_CNT];
    logic signed [Z_W-1:0]    r_z;
    logic signed [Z_W-1:0]    n_z;
    logic signed [Z_W-1:0]    w_atan;
    logic [STEP_W-1:0]        r_step;
    logic                     r_busy;
    logic                     r_fin;
    logic                     r_done;
    logic                     w_pos;
    logic [LANE_CNT-1:0][DATA_W-1:0] r_res;

    // Round half up to Q2.14 by dropping 16 fraction bits, then saturate.
    function automatic logic [DATA_W-1:0] round_q14(input logic signed [LANE_W-1:0] v);
        logic signed [LANE_W-1:0]    s;
        logic signed [LANE_W-17:0]   t;
        logic [DATA_W-1:0]           q;
        s = v + LANE_W'(32768);
        t = s[LANE_W-1:16];
        if (t > (LANE_W-16)'(32767)) begin
            q = 16'h7FFF;
        end else if (t < (LANE_W-16)'(-32768)) begin
            q = 16'h8000;
        end else begin
            q = t[DATA_W-1:0];
        end
        return q;
    endfunction

    // One micro-rotation: both vectors turn the same way as the residual angle says.
    always_comb begin
        w_pos  = !r_z[Z_W-1];
        w_atan = atan_q13(ATAN_IDX_W'(r_step));
        for (int l = 0; l < LANE_CNT; l++) begin
            w_sh[l] = r_x[l] >>> r_step;
        end
        for (int p = 0; p < LANE_CNT / 2; p++) begin
            if (w_pos) begin
                n_x[2*p]   = r_x[2*p] - w_sh[2*p+1];
                n_x[2*p+1] = r_x[2*p+1] + w_sh[2*p];
            end else begin
                n_x[2*p]   = r_x[2*p] + w_sh[2*p+1];
                n_x[2*p+1] = r_x[2*p+1] - w_sh[2*p];
            end
        end
        n_z = w_pos ? (r_z - w_atan) : (r_z + w_atan);
    end

    // Step counter, lane registers and the rounded results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_z    <= i_z;
            end else if (r_busy) begin
                for (int l = 0; l < LANE_CNT; l++) begin
                    r_x[l] <= n_x[l];
                end
                r_z    <= n_z;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (i_ctl.wr) begin
                r_x[i_ctl.lane] <= i_wr_data;
            end
            if (r_fin) begin
                for (int l = 0; l < LANE_CNT; l++) begin
                    r_res[l] <= round_q14(r_x[l]);
                end
                r_done <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy | r_fin;
    assign o_stat.done = r_done;
    assign o_res       = r_res;

endmodule

// File: design/view_vector_rotator.sv
// View vector rotator, top level: configuration registers, vector state, the
// sequencer and the shared multiplier. Depends on vvr_pkg, vvr_in_if,
// vvr_out_if and vvr_cordic.
//
// Usage: the block holds a view direction and a camera plane vector in Q2.14.
// Each beat on i_in carries an opcode and a frame time. Rotate left and right
// turn both vectors by rot_speed * frame_time (Q3.13, limited to pi/2) with an
// iterative CORDIC; restart loads the start registers; the unused opcode
// leaves the vectors as they are. Every input beat yields exactly one beat on
// o_out with the four updated components.
// Sequence of a rotation after the accepted beat: angle product, angle, four gain
// pre-scales on the shared multiplier, start, one micro-rotation per cycle,
// rounding, write-back and the output register. Restart and the unused opcode
// go from the accepted beat straight to the output register.
// Throughput: i_in.ready is high only while the sequencer is idle, so a new beat
// is accepted only once the previous one has left the sequencer.
// The result sits in an output register, so the next beat is accepted while it
// waits; if the receiver stalls, the following result waits in the sequencer.
// Reset (synchronous, active low) restores the register and vector reset
// values. Configuration writes via i_cfg_we are taken at any edge.
module view_vector_rotator #(
    parameter int CORDIC_STEPS = vvr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    vvr_in_if.sink                           i_in,
    vvr_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [vvr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vvr_pkg::DATA_W-1:0]       i_cfg_data
);
    import vvr_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    logic [OP_W-1:0]           r_op;
    logic [DATA_W-1:0]         r_ft;
    logic [DATA_W-1:0]         r_rot_speed;
    logic [DATA_W-1:0]         r_start_dir_x;
    logic [DATA_W-1:0]         r_start_dir_y;
    logic [DATA_W-1:0]         r_start_plane_x;
    logic [DATA_W-1:0]         r_start_plane_y;
    logic signed [DATA_W-1:0]  r_dir_x;
    logic signed [DATA_W-1:0]  r_dir_y;
    logic signed [DATA_W-1:0]  r_plane_x;
    logic signed [DATA_W-1:0]  r_plane_y;
    logic signed [PROD_W-1:0]  r_prod;
    logic [LANE_IDX_W-1:0]     r_lane;
    logic signed [Z_W-1:0]     r_z;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_dir_x;
    logic signed [DATA_W-1:0]  r_out_dir_y;
    logic signed [DATA_W-1:0]  r_out_plane_x;
    logic signed [DATA_W-1:0]  r_out_plane_y;

    logic signed [MUL_W-1:0]   w_ma;
    logic signed [MUL_W-1:0]   w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [DATA_W-1:0]  w_comp;
    logic [Z_W-1:0]            w_ang_raw;
    logic [Z_W-1:0]            w_ang_sat;
    logic signed [Z_W-1:0]     w_z;
    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_rotate;
    t_cor_ctl                  w_ctl;
    t_cor_stat                 w_stat;
    logic [LANE_CNT-1:0][DATA_W-1:0] w_res;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_rotate   = (i_in.opcode == OP_LEFT) || (i_in.opcode == OP_RIGHT);

    // Component chosen for the gain pre-scale
    always_comb begin
        case (r_lane)
            2'd0:    w_comp = r_dir_x;
            2'd1:    w_comp = r_dir_y;
            2'd2:    w_comp = r_plane_x;
            default: w_comp = r_plane_y;
        endcase
    end

    // Shared multiplier: angle product first, then each component times the gain.
    always_comb begin
        if (r_state == S_MUL) begin
            w_ma = $signed({1'b0, r_rot_speed});
            w_mb = $signed({1'b0, r_ft});
        end else begin
            w_ma = MUL_W'(w_comp);
            w_mb = $signed({1'b0, GAIN_K});
        end
        w_prod = w_ma * w_mb;
    end

    // Angle in Q3.13, limited to pi/2 and negated for a left turn.
    always_comb begin
        w_ang_raw = r_prod[31:15];
        w_ang_sat = (w_ang_raw > ANGLE_MAX) ? ANGLE_MAX : w_ang_raw;
        w_z       = (r_op == OP_LEFT) ? -$signed(w_ang_sat) : $signed(w_ang_sat);
    end

    // Next state and the CORDIC control
    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        w_ctl.lane = r_lane - 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_rotate ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                n_state = S_ANG;
            end
            S_ANG: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                w_ctl.wr = 1'b1;
                if (r_lane == '0) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                w_ctl.start = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (w_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_speed     <= RST_ROT_SPEED;
            r_start_dir_x   <= RST_START_DIR_X;
            r_start_dir_y   <= RST_START_DIR_Y;
            r_start_plane_x <= RST_START_PLANE_X;
            r_start_plane_y <= RST_START_PLANE_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT_SPEED:     r_rot_speed     <= i_cfg_data;
                REG_START_DIR_X:   r_start_dir_x   <= i_cfg_data;
                REG_START_DIR_Y:   r_start_dir_y   <= i_cfg_data;
                REG_START_PLANE_X: r_start_plane_x <= i_cfg_data;
                REG_START_PLANE_Y: r_start_plane_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Vector state: loaded on restart, updated when the CORDIC finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x   <= $signed(RST_START_DIR_X);
            r_dir_y   <= $signed(RST_START_DIR_Y);
            r_plane_x <= $signed(RST_START_PLANE_X);
            r_plane_y <= $signed(RST_START_PLANE_Y);
        end else if (w_in_acc && (i_in.opcode == OP_RESTART)) begin
            r_dir_x   <= $signed(r_start_dir_x);
            r_dir_y   <= $signed(r_start_dir_y);
            r_plane_x <= $signed(r_start_plane_x);
            r_plane_y <= $signed(r_start_plane_y);
        end else if ((r_state == S_RUN) && w_stat.done) begin
            r_dir_x   <= $signed(w_res[0]);
            r_dir_y   <= $signed(w_res[1]);
            r_plane_x <= $signed(w_res[2]);
            r_plane_y <= $signed(w_res[3]);
        end
    end

    // Input beat capture, product register, angle and lane counter
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_in_acc) begin
            r_op <= i_in.opcode;
            r_ft <= i_in.frame_time;
        end
        case (r_state)
            S_MUL: begin
                r_lane <= '0;
            end
            S_ANG: begin
                r_z    <= w_z;
                r_lane <= r_lane + 1'b1;
            end
            S_SCALE: begin
                r_lane <= r_lane + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: a result beat waits here until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid   <= 1'b1;
            r_out_dir_x   <= r_dir_x;
            r_out_dir_y   <= r_dir_y;
            r_out_plane_x <= r_plane_x;
            r_out_plane_y <= r_plane_y;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    vvr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_data (LANE_W'(r_prod)),
        .i_z       (r_z),
        .o_stat    (w_stat),
        .o_res     (w_res)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.dir_x   = r_out_dir_x;
    assign o_out.dir_y   = r_out_dir_y;
    assign o_out.plane_x = r_out_plane_x;
    assign o_out.plane_y = r_out_plane_y;

endmodule

// File: sim/view_vector_rotator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of view_vector_rotator: a clocked driver and monitor with
// random idling, checked beat by beat against an in-bench CORDIC predictor.
// Depends on vvr_pkg, vvr_in_if, vvr_out_if and the view_vector_rotator RTL.
module view_vector_rotator_tb;
    import vvr_pkg::*;

    localparam int STEPS            = CORDIC_STEPS_DEF;
    localparam int LATENCY          = STEPS + 10;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASE_COUNT      = 7;
    localparam int CHUNKS_PER_PHASE = 3;
    localparam int CHUNK_BEATS      = 49;

    // The opcode left free by the package, and register indexes the block ignores
    localparam logic [OP_W-1:0]      OP_SPARE        = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] frame_time;
    } t_beat;

    typedef struct packed {
        logic [DATA_W-1:0] dir_x;
        logic [DATA_W-1:0] dir_y;
        logic [DATA_W-1:0] plane_x;
        logic [DATA_W-1:0] plane_y;
    } t_vec_set;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_SKIP_FOURTH,
        RX_COIN,
        RX_LONG_STALL
    } t_rx_mode;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 in_vld   = 1'b0;
    logic [OP_W-1:0]      in_op    = '0;
    logic [DATA_W-1:0]    in_ft    = '0;
    logic                 out_rdy  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    // Predictor copy of the registers and of the two vectors
    logic [DATA_W-1:0]        speed_q412 = RST_ROT_SPEED;
    logic [DATA_W-1:0]        start_dx   = RST_START_DIR_X;
    logic [DATA_W-1:0]        start_dy   = RST_START_DIR_Y;
    logic [DATA_W-1:0]        start_px   = RST_START_PLANE_X;
    logic [DATA_W-1:0]        start_py   = RST_START_PLANE_Y;
    logic signed [DATA_W-1:0] dir_x_q    = RST_START_DIR_X;
    logic signed [DATA_W-1:0] dir_y_q    = RST_START_DIR_Y;
    logic signed [DATA_W-1:0] plane_x_q  = RST_START_PLANE_X;
    logic signed [DATA_W-1:0] plane_y_q  = RST_START_PLANE_Y;

    t_beat    pending_beats[$];
    t_vec_set expected_vectors[$];

    int       burst_left     = 0;
    int       gap_left       = 0;
    int       stall_tick     = 0;
    t_rx_mode stall_mode     = RX_OPEN;
    int       quiet_cycles   = 0;
    int       mismatches     = 0;
    int       beats_accepted = 0;
    int       results_seen   = 0;
    int       settings_used  = 1;
    int       op_counts[4]   = '{0, 0, 0, 0};

    vvr_in_if  in_ch ();
    vvr_out_if out_ch ();

    assign in_ch.valid      = in_vld;
    assign in_ch.opcode     = in_op;
    assign in_ch.frame_time = in_ft;
    assign out_ch.ready     = out_rdy;

    view_vector_rotator #(
        .CORDIC_STEPS(STEPS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Q2.30 accumulator to Q2.14, rounding half up and saturating.
    function automatic logic signed [DATA_W-1:0] round_q14(input longint acc);
        longint r;
        r = (acc + 64'sd32768) >>> 16;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r[DATA_W-1:0];
    endfunction

    // Gain-compensated CORDIC in rotation mode; the arctangent steps are
    // worked out from $atan and rounded to Q3.13.
    function automatic void cordic_turn(inout logic signed [DATA_W-1:0] cx,
                                        inout logic signed [DATA_W-1:0] cy,
                                        input int angle);
        longint x, y, xs, ys;
        int     z, step_angle;
        x = longint'(cx) * longint'(GAIN_K);
        y = longint'(cy) * longint'(GAIN_K);
        z = angle;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step_angle = $rtoi($atan(2.0 ** (-i)) * 8192.0 + 0.5);
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - step_angle;
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + step_angle;
            end
        end
        cx = round_q14(x);
        cy = round_q14(y);
    endfunction

    // Applies one accepted beat to the predicted vectors and returns them.
    function automatic t_vec_set advance_view(input t_beat b);
        logic [31:0] prod;
        int          angle;
        t_vec_set    r;
        prod  = speed_q412 * b.frame_time;
        angle = int'(prod >> 15);
        if (angle > int'(ANGLE_MAX))
            angle = int'(ANGLE_MAX);
        if (b.opcode == OP_LEFT)
            angle = -angle;
        if (b.opcode == OP_LEFT || b.opcode == OP_RIGHT) begin
            cordic_turn(dir_x_q, dir_y_q, angle);
            cordic_turn(plane_x_q, plane_y_q, angle);
        end else if (b.opcode == OP_RESTART) begin
            dir_x_q   = start_dx;
            dir_y_q   = start_dy;
            plane_x_q = start_px;
            plane_y_q = start_py;
        end
        r.dir_x   = dir_x_q;
        r.dir_y   = dir_y_q;
        r.plane_x = plane_x_q;
        r.plane_y = plane_y_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [DATA_W-1:0] want,
                                        input logic signed [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 40)
            b.opcode = OP_RIGHT;
        else if (pick < 80)
            b.opcode = OP_LEFT;
        else if (pick < 92)
            b.opcode = OP_RESTART;
        else
            b.opcode = OP_SPARE;
        // Mostly plausible frame times, with a good share of the full range
        pick = $urandom_range(99);
        if (pick < 35)
            b.frame_time = DATA_W'($urandom_range(1500));
        else if (pick < 50)
            b.frame_time = DATA_W'($urandom_range(20000, 1500));
        else if (pick < 90)
            b.frame_time = DATA_W'($urandom);
        else if (pick < 95)
            b.frame_time = {DATA_W{1'b1}};
        else
            b.frame_time = DATA_W'(1) << $urandom_range(DATA_W - 1);
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] random_start();
        if ($urandom_range(9) < 7)
            return DATA_W'($urandom_range(32768) - 16384);
        return DATA_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] random_speed();
        case ($urandom_range(4))
            0:       return '0;
            1:       return {DATA_W{1'b1}};
            2:       return DATA_W'($urandom);
            3:       return DATA_W'($urandom_range(4096, 1));
            default: return RST_ROT_SPEED;
        endcase
    endfunction

    task automatic push_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] ft);
        pending_beats.push_back({op, ft});
    endtask

    // Holds the caller until every queued beat has gone in and come back out.
    task automatic wait_all_results();
        while (pending_beats.size() != 0 || in_vld || expected_vectors.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write at the next edge; the predictor copy follows at once,
    // which is safe because writes happen only while the block is idle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_ROT_SPEED:     speed_q412 = val;
            REG_START_DIR_X:   start_dx   = val;
            REG_START_DIR_Y:   start_dy   = val;
            REG_START_PLANE_X: start_px   = val;
            REG_START_PLANE_Y: start_py   = val;
            default: ;
        endcase
    endtask

    // Writes every register, then one index that the block must ignore.
    task automatic load_config(input logic [DATA_W-1:0] rs, input logic [DATA_W-1:0] dx,
                               input logic [DATA_W-1:0] dy, input logic [DATA_W-1:0] px,
                               input logic [DATA_W-1:0] py);
        cfg_write(REG_ROT_SPEED, rs);
        cfg_write(REG_START_DIR_X, dx);
        cfg_write(REG_START_DIR_Y, dy);
        cfg_write(REG_START_PLANE_X, px);
        cfg_write(REG_START_PLANE_Y, py);
        cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  DATA_W'($urandom));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Input driver: bursts of random length with random gaps in between.
    always @(posedge i_clk) begin : input_driver
        t_beat head;
        if (!i_rst_n) begin
            in_vld <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_vectors.push_back(advance_view({in_op, in_ft}));
                op_counts[in_op]++;
                beats_accepted++;
            end
            if (!in_vld || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_vld <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    head = pending_beats.pop_front();
                    in_vld <= 1'b1;
                    in_op  <= head.opcode;
                    in_ft  <= head.frame_time;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end else begin
                    in_vld <= 1'b0;
                end
            end
        end
    end

    // Result monitor, with a receiver that periodically picks a random stall pattern.
    always @(posedge i_clk) begin : result_monitor
        t_vec_set want;
        if (!i_rst_n) begin
            out_rdy <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_vectors.size() == 0) begin
                    $error("result beat with no outstanding input beat");
                    mismatches++;
                end else begin
                    want = expected_vectors.pop_front();
                    check_field("dir_x", want.dir_x, out_ch.dir_x);
                    check_field("dir_y", want.dir_y, out_ch.dir_y);
                    check_field("plane_x", want.plane_x, out_ch.plane_x);
                    check_field("plane_y", want.plane_y, out_ch.plane_y);
                end
            end
            stall_tick++;
            if (stall_tick % 40 == 0)
                stall_mode = t_rx_mode'($urandom_range(3));
            case (stall_mode)
                RX_OPEN:        out_rdy <= 1'b1;
                RX_SKIP_FOURTH: out_rdy <= (stall_tick % 4) != 0;
                RX_COIN:        out_rdy <= 1'($urandom_range(1));
                default:        out_rdy <= (stall_tick % 12) >= 9;
            endcase
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("view_vector_rotator regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: zero frame time, typical frames, saturated angles, unused opcode, restart
        push_beat(OP_LEFT, 16'd0);
        push_beat(OP_RIGHT, 16'd0);
        push_beat(OP_RIGHT, 16'd1092);
        push_beat(OP_LEFT, 16'd1092);
        push_beat(OP_RIGHT, 16'hFFFF);
        push_beat(OP_LEFT, 16'hFFFF);
        push_beat(OP_SPARE, 16'h5A5A);
        push_beat(OP_RESTART, 16'd0);
        push_beat(OP_SPARE, 16'hFFFF);
        wait_all_results();

        // Extreme speed and start vectors large enough to saturate on rotation
        load_config(16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        push_beat(OP_RESTART, 16'hFFFF);
        push_beat(OP_RIGHT, 16'hFFFF);
        push_beat(OP_LEFT, 16'd1);
        push_beat(OP_RIGHT, 16'h8000);
        push_beat(OP_LEFT, 16'hFFFF);
        wait_all_results();

        // Zero speed and zero vectors
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_beat(OP_RESTART, 16'h1234);
        push_beat(OP_RIGHT, 16'hFFFF);
        push_beat(OP_LEFT, 16'hFFFF);
        wait_all_results();

        // Smallest non-zero speed
        load_config(16'd1, 16'h8000, 16'h8000, 16'h7FFF, 16'd0);
        push_beat(OP_RESTART, 16'd0);
        push_beat(OP_RIGHT, 16'hFFFF);
        push_beat(OP_LEFT, 16'h7FFF);
        wait_all_results();

        // Random settings; the sender drains fully between chunks
        for (int p = 0; p < PHASE_COUNT; p++) begin
            load_config(random_speed(), random_start(), random_start(), random_start(),
                        random_start());
            push_beat(OP_RESTART, DATA_W'($urandom));
            for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
                for (int n = 0; n < CHUNK_BEATS; n++)
                    pending_beats.push_back(random_beat());
                wait_all_results();
            end
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_vectors.size() != 0) begin
            $error("%0d expected results never arrived", expected_vectors.size());
            mismatches++;
        end

        $display("Covered %0d input beats and %0d result beats over %0d register settings.",
                 beats_accepted, results_seen, settings_used);
        $display("Opcodes: %0d left, %0d right, %0d restart, %0d unused; %0d mismatches.",
                 op_counts[OP_LEFT], op_counts[OP_RIGHT], op_counts[OP_RESTART],
                 op_counts[OP_SPARE], mismatches);
        if (mismatches == 0)
            $display("view_vector_rotator regression: pass");
        else
            $display("view_vector_rotator regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/vvr_pkg.sv
design/vvr_in_if.sv
design/vvr_out_if.sv
design/vvr_cordic.sv
design/view_vector_rotator.sv
sim/view_vector_rotator_tb.sv
